// File: hdl/ssa_pkg.sv
// Shared types and constants for the superblock slot allocator.
// No dependencies; imported by every module of the block.
package ssa_pkg;

  localparam int SLOTS_DEF     = 512;
  localparam int SIZE_BITS_DEF = 16;

  localparam int CAP_W   = 10;  // slot_capacity register
  localparam int LIMIT_W = 16;  // slot_size_limit register and request size
  localparam int CFG_W   = 16;  // config write data, widest register
  localparam int USED_W  = 25;  // used-byte count

  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(512);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NOT_LIVE  = 2'd3
  } ssa_status_e;

  typedef enum logic {
    CFG_CAPACITY   = 1'b0,
    CFG_SIZE_LIMIT = 1'b1
  } ssa_cfg_reg_e;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;  // latch input word, launch memory reads
    logic commit;  // apply updates, load result word
  } ssa_cmd_t;

endpackage

// File: hdl/superblock_slot_allocator.sv
// An accepted input word is latched together with a registered read of the free stack, size
// and live memories; an update step then writes them and loads the result word. A new word
// is not accepted until the last one is through. A stalled result delays the update step.
// Reset (async, active low) clears bump index, stack depth, byte count and handshake state;
// live bits need no clearing pass since slots at or above the bump index read as not live.
module superblock_slot_allocator import ssa_pkg::*; #(
  parameter  int SLOTS     = SLOTS_DEF,
  parameter  int SIZE_BITS = SIZE_BITS_DEF,
  localparam int IdxW      = $clog2(SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [LIMIT_W-1:0]   request_size_i,
  input  logic [SIZE_BITS-1:0] data_size_i,
  input  logic [IdxW-1:0]      slot_to_free_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [IdxW-1:0]      granted_slot_o,
  output logic [USED_W-1:0]    bytes_in_use_o
);

  ssa_cmd_t cmd;

  ssa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ssa_datapath #(
    .SLOTS     (SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .data_size_i    (data_size_i),
    .slot_to_free_i (slot_to_free_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .bytes_in_use_o (bytes_in_use_o)
  );

endmodule

// File: hdl/ssa_ctrl.sv
// Sequencing FSM for the slot allocator: input/output handshake and datapath commands.
// Depends on ssa_pkg.
module ssa_ctrl import ssa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ssa_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    // finish only when the result register is free or drains this cycle
    cmd_o.commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/ssa_datapath.sv
// Allocator datapath: config registers, bump index, free stack, slot size and live memories,
// used-byte counter and result register. Depends on ssa_pkg.
module ssa_datapath import ssa_pkg::*; #(
  parameter  int SLOTS     = SLOTS_DEF,
  parameter  int SIZE_BITS = SIZE_BITS_DEF,
  localparam int IdxW      = $clog2(SLOTS),
  localparam int CntW      = $clog2(SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssa_cmd_t             cmd_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 operation_i,
  input  logic [LIMIT_W-1:0]   request_size_i,
  input  logic [SIZE_BITS-1:0] data_size_i,
  input  logic [IdxW-1:0]      slot_to_free_i,
  output logic [1:0]           status_o,
  output logic [IdxW-1:0]      granted_slot_o,
  output logic [USED_W-1:0]    bytes_in_use_o
);

  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;
  localparam int SumW = ((SIZE_BITS > USED_W) ? SIZE_BITS : USED_W) + 1;
  localparam logic [USED_W-1:0] UsedMax = '1;

  logic [CAP_W-1:0]   cap_q;
  logic [LIMIT_W-1:0] lim_q;
  logic [CntW-1:0]    fresh_q, fresh_d;
  logic [CntW-1:0]    depth_q, depth_d;
  logic [USED_W-1:0]  used_q, used_d;

  logic [IdxW-1:0]      stack_mem [SLOTS];
  logic [SIZE_BITS-1:0] bytes_mem [SLOTS];
  logic                 live_mem  [SLOTS];

  // latched input word and registered memory read data
  logic                 op_q;
  logic [LIMIT_W-1:0]   req_q;
  logic [SIZE_BITS-1:0] dsz_q;
  logic [IdxW-1:0]      victim_q;
  logic [IdxW-1:0]      stk_rd_q;
  logic [SIZE_BITS-1:0] bytes_rd_q;
  logic                 live_rd_q;

  logic [1:0]      status_q, status_d;
  logic [IdxW-1:0] granted_q, granted_d;

  logic [CmpW-1:0] eff_cap;
  logic [IdxW-1:0] stk_raddr;
  logic            size_ok, fresh_ok, pop_ok, grant_ok, free_ok, push_ok;
  logic [IdxW-1:0] grant_slot;
  logic [SumW-1:0] add_sum, sub_diff;
  logic            stk_we, bytes_we, live_we, live_wdata;
  logic [IdxW-1:0] live_waddr;

  always_comb begin
    eff_cap = (CmpW'(cap_q) > CmpW'(SLOTS)) ? CmpW'(SLOTS) : CmpW'(cap_q);
    stk_raddr = IdxW'(depth_q - CntW'(1));

    size_ok  = (req_q <= lim_q);
    fresh_ok = (CmpW'(fresh_q) < eff_cap);
    pop_ok   = (depth_q != '0);
    grant_ok = size_ok && (fresh_ok || pop_ok);
    grant_slot = fresh_ok ? fresh_q[IdxW-1:0] : stk_rd_q;

    // entries at or above the bump index were never granted, so never live
    free_ok = (CmpW'(victim_q) < eff_cap) && (CmpW'(victim_q) < CmpW'(fresh_q)) && live_rd_q;
    push_ok = (depth_q < CntW'(SLOTS));

    add_sum  = SumW'(used_q) + SumW'(dsz_q);
    sub_diff = SumW'(used_q) - SumW'(bytes_rd_q);

    fresh_d    = fresh_q;
    depth_d    = depth_q;
    used_d     = used_q;
    stk_we     = 1'b0;
    bytes_we   = 1'b0;
    live_we    = 1'b0;
    live_waddr = grant_slot;
    live_wdata = 1'b1;
    granted_d  = '0;
    status_d   = ST_OK;

    if (op_q == OP_ALLOC) begin
      if (!size_ok) begin
        status_d = ST_TOO_LARGE;
      end else if (!grant_ok) begin
        status_d = ST_NO_SLOT;
      end else begin
        granted_d = grant_slot;
        live_we   = 1'b1;
        bytes_we  = 1'b1;
        if (fresh_ok) begin
          fresh_d = fresh_q + CntW'(1);
        end else begin
          depth_d = depth_q - CntW'(1);
        end
        used_d = (add_sum > SumW'(UsedMax)) ? UsedMax : add_sum[USED_W-1:0];
      end
    end else begin
      if (!free_ok) begin
        status_d = ST_NOT_LIVE;
      end else begin
        live_we    = 1'b1;
        live_waddr = victim_q;
        live_wdata = 1'b0;
        if (push_ok) begin
          stk_we  = 1'b1;
          depth_d = depth_q + CntW'(1);
        end
        used_d = (SumW'(used_q) >= SumW'(bytes_rd_q)) ? sub_diff[USED_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      lim_q   <= LIMIT_RESET;
      fresh_q <= '0;
      depth_q <= '0;
      used_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY:   cap_q <= cfg_wdata_i[CAP_W-1:0];
          CFG_SIZE_LIMIT: lim_q <= cfg_wdata_i[LIMIT_W-1:0];
          default:        ;
        endcase
      end
      if (cmd_i.commit) begin
        fresh_q <= fresh_d;
        depth_q <= depth_d;
        used_q  <= used_d;
      end
    end
  end

  // input latch and memory reads, registered ahead of the update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= operation_i;
      req_q      <= request_size_i;
      dsz_q      <= data_size_i;
      victim_q   <= slot_to_free_i;
      stk_rd_q   <= stack_mem[stk_raddr];
      bytes_rd_q <= bytes_mem[slot_to_free_i];
      live_rd_q  <= live_mem[slot_to_free_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stk_we) begin
      stack_mem[depth_q[IdxW-1:0]] <= victim_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && bytes_we) begin
      bytes_mem[grant_slot] <= dsz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign bytes_in_use_o = used_q;

endmodule

// File: hdl/ssa_checker.sv
// Port-level assertions for the slot allocator, bound to the top level.
// Depends on ssa_pkg and superblock_slot_allocator.
module ssa_checker import ssa_pkg::*; #(
  parameter  int SLOTS     = SLOTS_DEF,
  parameter  int SIZE_BITS = SIZE_BITS_DEF,
  localparam int IdxW      = $clog2(SLOTS)
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [IdxW-1:0]      granted_slot_o,
  input logic [USED_W-1:0]    bytes_in_use_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(granted_slot_o) && $stable(bytes_in_use_o))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an accepted word");

  // failed operations grant nothing
  a_no_grant_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> granted_slot_o == '0)
    else $error("slot granted on error status");

endmodule

bind superblock_slot_allocator ssa_checker #(
  .SLOTS     (SLOTS),
  .SIZE_BITS (SIZE_BITS)
) u_ssa_checker (.*);
